@@ rtl/iol_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed ordered list package
// Shared constants, codes and the control broadcast that the top level sends
// along the row of storage cells.
// ----------------------------------------------------------------------------
package iol_pkg;

    // Default number of cells in the row.
    localparam int IOL_CAPACITY = 16;

    // Field widths fixed by the stream format.
    localparam int IOL_MODE_W   = 3;
    localparam int IOL_POS_W    = 8;
    localparam int IOL_VAL_W    = 32;
    localparam int IOL_CNT_W    = 7;
    localparam int IOL_STAT_W   = 2;
    localparam int IOL_S_DATA_W = 40;
    localparam int IOL_M_DATA_W = 40;

    // Operation requested by an input transaction.
    typedef enum logic [IOL_MODE_W-1:0] {
        MODE_READ   = 3'd0,
        MODE_PUSH   = 3'd1,
        MODE_APPEND = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_LIST   = 3'd4
    } t_iol_mode;

    // Status returned with each result.
    typedef enum logic [IOL_STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_iol_status;

    // What every cell does in the current cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_APPEND = 2'd2,
        OP_REMOVE = 2'd3
    } t_iol_op;

    // Control broadcast to all cells: the operation, the position from which
    // a removal closes the gap, and the index of the first free cell.
    typedef struct packed {
        t_iol_op              op;
        logic [IOL_POS_W-1:0] pos;
        logic [IOL_POS_W-1:0] tail;
    } t_iol_bcast;

endpackage

@@ rtl/indexed_ordered_list.sv @@
// Each result is registered; it appears on the master side in the cycle after its input.
// Read, insert, append and remove accept a new item whenever the output register is free.
// A list of n entries produces n results, one per cycle unless the output stalls; the next item waits until the last.
// The listing index drives the single read port, so a listing holds the input side off.
// Reset (synchronous, active low) clears the count, the listing state and the output valid
// flag and holds the input side off, with no clearing pass; cells are undefined until written.
// ----------------------------------------------------------------------------
// Indexed ordered list
// A bounded ordered list of signed values kept in a row of cells, with read,
// insert at front, append, remove at position and list-all operations.
// ----------------------------------------------------------------------------
module indexed_ordered_list #(
    parameter int CAPACITY = iol_pkg::IOL_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] position, [39:8] value
    input  logic [iol_pkg::IOL_S_DATA_W-1:0]    s_tdata,
    // [2:0] mode
    input  logic [iol_pkg::IOL_MODE_W-1:0]      s_tuser,
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] data, [38:32] entry_count, [39] zero
    output logic [iol_pkg::IOL_M_DATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [iol_pkg::IOL_STAT_W-1:0]      m_tuser,
    output logic                                m_tlast
);
    import iol_pkg::*;

    localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CntW = $clog2(CAPACITY + 1);

    // Input fields.
    logic [IOL_POS_W-1:0]        w_pos;
    logic signed [IOL_VAL_W-1:0] w_value;
    t_iol_mode                   w_mode;

    assign w_pos   = s_tdata[IOL_POS_W-1:0];
    assign w_value = s_tdata[IOL_POS_W +: IOL_VAL_W];
    assign w_mode  = t_iol_mode'(s_tuser);

    // Control and output registers.
    logic                        r_listing;
    logic                        n_listing;
    logic [IdxW-1:0]             r_idx;
    logic [IdxW-1:0]             n_idx;
    logic [CntW-1:0]             r_count;
    logic [CntW-1:0]             n_count;
    logic                        r_m_valid;
    logic                        n_m_valid;
    logic signed [IOL_VAL_W-1:0] r_m_data;
    logic signed [IOL_VAL_W-1:0] n_m_data;
    t_iol_status                 r_m_status;
    t_iol_status                 n_m_status;
    logic                        r_m_last;
    logic                        n_m_last;

    // Cell row.
    logic signed [IOL_VAL_W-1:0] w_cell [CAPACITY];
    t_iol_bcast                  w_bcast;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [IOL_VAL_W-1:0] w_prev;
            logic signed [IOL_VAL_W-1:0] w_next;

            if (g == 0) begin : g_front
                assign w_prev = w_value;
            end else begin : g_inner_prev
                assign w_prev = w_cell[g-1];
            end

            if (g == CAPACITY - 1) begin : g_back
                assign w_next = '0;
            end else begin : g_inner_next
                assign w_next = w_cell[g+1];
            end

            iol_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_bcast (w_bcast),
                .i_value (w_value),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    // Handshake: the output register is free when empty or being taken.
    logic w_out_free;
    logic w_accept;

    assign w_out_free = !r_m_valid || m_tready;
    assign s_tready   = i_rst_n && !r_listing && w_out_free;
    assign w_accept   = s_tvalid && s_tready;

    // Single read port on the row: listing index, or the requested position.
    logic [IdxW-1:0]             w_raddr;
    logic signed [IOL_VAL_W-1:0] w_rdata;
    logic                        w_pos_ok;
    logic                        w_full;
    logic [CntW-1:0]             w_idx_inc;

    always_comb begin
        if (r_listing) begin
            w_raddr = r_idx;
        end else if (w_mode == MODE_LIST) begin
            w_raddr = '0;
        end else begin
            w_raddr = w_pos[IdxW-1:0];
        end
    end

    assign w_rdata   = w_cell[w_raddr];
    assign w_pos_ok  = w_pos < IOL_POS_W'(r_count);
    assign w_full    = r_count == CntW'(CAPACITY);
    assign w_idx_inc = CntW'(r_idx) + CntW'(1);

    // Operation decode and next-state logic.
    always_comb begin
        n_listing    = r_listing;
        n_idx        = r_idx;
        n_count      = r_count;
        n_m_valid    = r_m_valid && !m_tready;
        n_m_data     = r_m_data;
        n_m_status   = r_m_status;
        n_m_last     = r_m_last;
        w_bcast.op   = OP_HOLD;
        w_bcast.pos  = w_pos;
        w_bcast.tail = IOL_POS_W'(r_count);

        if (r_listing) begin
            // Stream one entry per free output slot.
            if (w_out_free) begin
                n_m_valid  = 1'b1;
                n_m_data   = w_rdata;
                n_m_status = STAT_OK;
                n_m_last   = w_idx_inc == r_count;
                n_idx      = w_idx_inc[IdxW-1:0];
                if (w_idx_inc == r_count) begin
                    n_listing = 1'b0;
                end
            end
        end else if (w_accept) begin
            n_m_valid  = 1'b1;
            n_m_data   = '0;
            n_m_status = STAT_OK;
            n_m_last   = 1'b1;
            case (w_mode)
                MODE_READ: begin
                    if (w_pos_ok) begin
                        n_m_data = w_rdata;
                    end else begin
                        n_m_data   = '1;
                        n_m_status = STAT_RANGE;
                    end
                end
                MODE_PUSH: begin
                    if (w_full) begin
                        n_m_status = STAT_FULL;
                    end else begin
                        w_bcast.op = OP_PUSH;
                        n_count    = r_count + CntW'(1);
                    end
                end
                MODE_APPEND: begin
                    if (w_full) begin
                        n_m_status = STAT_FULL;
                    end else begin
                        w_bcast.op = OP_APPEND;
                        n_count    = r_count + CntW'(1);
                    end
                end
                MODE_REMOVE: begin
                    if (w_pos_ok) begin
                        w_bcast.op = OP_REMOVE;
                        n_count    = r_count - CntW'(1);
                    end else begin
                        n_m_status = STAT_RANGE;
                    end
                end
                MODE_LIST: begin
                    if (r_count == '0) begin
                        n_m_status = STAT_EMPTY;
                    end else begin
                        // The front entry goes out now; the rest follow.
                        n_m_data = w_rdata;
                        n_m_last = r_count == CntW'(1);
                        if (r_count != CntW'(1)) begin
                            n_listing = 1'b1;
                            n_idx     = IdxW'(1);
                        end
                    end
                end
                default: begin
                    n_m_status = STAT_OK;
                end
            endcase
        end
    end

    // Control state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listing <= 1'b0;
            r_idx     <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_listing <= n_listing;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
        r_m_data   <= n_m_data;
        r_m_status <= n_m_status;
        r_m_last   <= n_m_last;
    end

    // The count reported is always the count after the operation.
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {1'b0, IOL_CNT_W'(r_count), r_m_data};
    assign m_tuser  = r_m_status;
    assign m_tlast  = r_m_last;

endmodule

@@ rtl/iol_cell.sv @@
// ----------------------------------------------------------------------------
// Indexed ordered list storage cell
// Holds one entry and decides from the broadcast whether to keep it, take the
// entry of its front neighbour, take the entry of its back neighbour or load
// the incoming value.
// ----------------------------------------------------------------------------
module iol_cell #(
    parameter int IDX = 0
) (
    input  logic                                 i_clk,
    input  iol_pkg::t_iol_bcast                  i_bcast,
    input  logic signed [iol_pkg::IOL_VAL_W-1:0] i_value,
    input  logic signed [iol_pkg::IOL_VAL_W-1:0] i_prev,
    input  logic signed [iol_pkg::IOL_VAL_W-1:0] i_next,
    output logic signed [iol_pkg::IOL_VAL_W-1:0] o_data
);
    import iol_pkg::*;

    localparam logic [IOL_POS_W-1:0] MyIdx = IOL_POS_W'(IDX);

    logic signed [IOL_VAL_W-1:0] r_data;
    logic signed [IOL_VAL_W-1:0] n_data;

    // Select the next content of this cell.
    always_comb begin
        n_data = r_data;
        case (i_bcast.op)
            OP_PUSH: begin
                n_data = i_prev;
            end
            OP_APPEND: begin
                if (i_bcast.tail == MyIdx) begin
                    n_data = i_value;
                end
            end
            OP_REMOVE: begin
                if (MyIdx >= i_bcast.pos) begin
                    n_data = i_next;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // Entry storage; no reset, only cells below the count are ever read.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ verif/indexed_ordered_list_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed ordered list testbench
// Drives read, insert, append, remove, list and unused-mode transactions into
// the list. A local copy of the cell row predicts every result, and each
// result leaving the block is compared field by field with the oldest
// prediction. Both stream sides idle at random, with some stretches at full
// rate.
// ----------------------------------------------------------------------------
module indexed_ordered_list_test;

    import iol_pkg::*;

    localparam int CAPACITY   = IOL_CAPACITY;
    localparam int DRAIN_WAIT = 10;
    // Modes above the list operation are unused and must be ignored.
    localparam logic [IOL_MODE_W-1:0] MODE_RSVD_LO = 3'd5;
    localparam logic [IOL_MODE_W-1:0] MODE_RSVD_HI = 3'd7;

    // One result as the list should deliver it.
    typedef struct {
        logic [IOL_VAL_W-1:0] data;
        t_iol_status          status;
        logic [IOL_CNT_W-1:0] count;
        logic                 last;
    } t_list_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // [7:0] position, [39:8] value
    logic [IOL_S_DATA_W-1:0]   s_tdata = '0;
    // [2:0] mode
    logic [IOL_MODE_W-1:0]     s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // [31:0] data, [38:32] entry_count, [39] zero
    logic [IOL_M_DATA_W-1:0]   m_tdata;
    // [1:0] status
    logic [IOL_STAT_W-1:0]     m_tuser;
    logic                      m_tlast;

    // Local copy of the list contents and the results still owed.
    logic [IOL_VAL_W-1:0]      shadow_cells [CAPACITY];
    int                        held_count = 0;
    t_list_result              pending_results [$];
    int                        mismatch_count = 0;
    bit                        tx_idle_on = 1'b1;
    bit                        rx_idle_on = 1'b1;
    int                        rx_hold = 0;

    indexed_ordered_list #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Print one mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Queue one predicted result.
    function automatic void owe_result(input logic [IOL_VAL_W-1:0] data,
                                       input t_iol_status status, input logic last);
        t_list_result r;
        r.data   = data;
        r.status = status;
        r.count  = held_count[IOL_CNT_W-1:0];
        r.last   = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Apply one operation to the local list and predict its results.
    function automatic void apply_list_op(input logic [IOL_MODE_W-1:0] mode,
                                          input logic [IOL_POS_W-1:0] pos,
                                          input logic [IOL_VAL_W-1:0] val);
        case (mode)
            MODE_READ: begin
                if (pos >= held_count)
                    owe_result('1, STAT_RANGE, 1'b1);
                else
                    owe_result(shadow_cells[pos], STAT_OK, 1'b1);
            end
            MODE_PUSH: begin
                if (held_count >= CAPACITY) begin
                    owe_result('0, STAT_FULL, 1'b1);
                end else begin
                    for (int i = held_count; i > 0; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[0] = val;
                    held_count++;
                    owe_result('0, STAT_OK, 1'b1);
                end
            end
            MODE_APPEND: begin
                if (held_count >= CAPACITY) begin
                    owe_result('0, STAT_FULL, 1'b1);
                end else begin
                    shadow_cells[held_count] = val;
                    held_count++;
                    owe_result('0, STAT_OK, 1'b1);
                end
            end
            MODE_REMOVE: begin
                if (pos >= held_count) begin
                    owe_result('0, STAT_RANGE, 1'b1);
                end else begin
                    for (int i = pos; i + 1 < held_count; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    held_count--;
                    owe_result('0, STAT_OK, 1'b1);
                end
            end
            MODE_LIST: begin
                if (held_count == 0) begin
                    owe_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < held_count; i++)
                        owe_result(shadow_cells[i], STAT_OK, i + 1 == held_count);
                end
            end
            default: begin
                // Unused modes leave the list alone.
                owe_result('0, STAT_OK, 1'b1);
            end
        endcase
    endfunction

    // Send one transaction after a random gap and wait until it is taken.
    task automatic issue_op(input logic [IOL_MODE_W-1:0] mode,
                            input logic [IOL_POS_W-1:0] pos,
                            input logic [IOL_VAL_W-1:0] val);
        int gap;
        gap = tx_idle_on ? $urandom_range(7, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos};
        s_tuser  <= mode;
        apply_list_op(mode, pos, val);
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Hold the input side off until every owed result has arrived.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Draw one transaction, mostly well formed, biased to grow or shrink.
    task automatic random_op(input int grow_pct);
        int                    pick;
        logic [IOL_MODE_W-1:0] mode;
        logic [IOL_POS_W-1:0]  pos;
        pick = $urandom_range(99, 0);
        if (pick < 5)
            mode = IOL_MODE_W'($urandom_range(MODE_RSVD_HI, MODE_RSVD_LO));
        else if (pick < 13)
            mode = MODE_LIST;
        else if (pick < 33)
            mode = MODE_READ;
        else if ($urandom_range(99, 0) < grow_pct)
            mode = $urandom_range(1, 0) ? MODE_PUSH : MODE_APPEND;
        else
            mode = MODE_REMOVE;
        // Mostly positions up to the count, which includes the first one out of range.
        if ($urandom_range(9, 0) == 0)
            pos = IOL_POS_W'($urandom_range(255, 0));
        else
            pos = IOL_POS_W'($urandom_range(held_count, 0));
        issue_op(mode, pos, $urandom());
    endtask

    // Operations on an empty list.
    task automatic test_empty_store();
        issue_op(MODE_LIST, '0, '0);
        issue_op(MODE_READ, 8'd0, '0);
        issue_op(MODE_READ, 8'hFF, '1);
        issue_op(MODE_REMOVE, 8'd0, '0);
    endtask

    // Unused modes must give a plain result and change nothing.
    task automatic test_unused_modes();
        for (int m = MODE_RSVD_LO; m <= MODE_RSVD_HI; m++)
            issue_op(m[IOL_MODE_W-1:0], 8'hFF, '1);
    endtask

    // Fill with extreme values, then try to overfill and look at both ends.
    task automatic test_fill_to_capacity();
        logic [IOL_VAL_W-1:0] val;
        for (int i = 0; i < CAPACITY; i++) begin
            case (i)
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = 32'hFFFF_FFFF;
                3: val = 32'h0000_0000;
                default: val = $urandom();
            endcase
            issue_op(i[0] ? MODE_APPEND : MODE_PUSH, '0, val);
        end
        issue_op(MODE_PUSH, '0, 32'h1234_5678);
        issue_op(MODE_APPEND, '0, 32'h8765_4321);
        issue_op(MODE_LIST, '0, '0);
        issue_op(MODE_READ, IOL_POS_W'(CAPACITY - 1), '0);
        issue_op(MODE_REMOVE, IOL_POS_W'(CAPACITY), '0);
    endtask

    // Random traffic with a given bias towards growing the list.
    task automatic test_random_traffic(input int items, input int grow_pct);
        repeat (items) random_op(grow_pct);
    endtask

    // Receiver: after each result it may stall for a random number of cycles.
    always @(posedge i_clk) begin : rx_side
        int wait_cycles;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tvalid && m_tready) begin
            wait_cycles = rx_idle_on ? $urandom_range(7, 0) : 0;
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold  <= wait_cycles;
            end
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1)
                m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare every result transaction with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[IOL_VAL_W-1:0] !== want.data)
                    report_mismatch("data", m_tdata[IOL_VAL_W-1:0], want.data);
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[IOL_VAL_W +: IOL_CNT_W] !== want.count)
                    report_mismatch("entry count", 32'(m_tdata[IOL_VAL_W +: IOL_CNT_W]),
                                    32'(want.count));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // Stop a run that hangs.
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // Sequence of tests.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_unused_modes();
        test_fill_to_capacity();
        wait_for_results();

        // Shrink from full with both sides idling.
        test_random_traffic(25, 30);
        wait_for_results();

        // Full-rate stretch, biased to grow.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(25, 70);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        test_random_traffic(25, 50);
        wait_for_results();

        if (pending_results.size() > 0)
            report_mismatch("results never delivered", pending_results.size(), '0);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ indexed_ordered_list.f @@
rtl/iol_pkg.sv
rtl/iol_cell.sv
rtl/indexed_ordered_list.sv
verif/indexed_ordered_list_test.sv
